>>> design/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared codes, widths and control structs of the go-back-n sender.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

   localparam int CMD_W    = 2;
   localparam int DATA_W   = 8;
   localparam int ACK_W    = 4;
   localparam int STATUS_W = 3;

   // command codes
   localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] RSP_FRAME   = 3'd0;
   localparam logic [STATUS_W-1:0] RSP_ACK_OK  = 3'd1;
   localparam logic [STATUS_W-1:0] RSP_ACK_BAD = 3'd2;
   localparam logic [STATUS_W-1:0] RSP_FULL    = 3'd3;
   localparam logic [STATUS_W-1:0] RSP_EMPTY   = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_REPLAY = 2'b10
   } gbn_state_type;

   // controller -> datapath, at most one flag set per cycle
   typedef struct packed {
      logic op_send;
      logic op_ack_ok;
      logic op_ack_bad;
      logic op_full;
      logic op_empty;
      logic replay_load;
      logic replay_step;
   } gbn_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic window_full;
      logic count_zero;
      logic ack_match;
      logic replay_last;
   } gbn_stat_type;

endpackage

`default_nettype wire

>>> design/gbn_datapath.sv
// ----------------------------------------------------------------------------
// gbn_datapath
// Window pointers, outstanding count, frame store and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbn_datapath #(
   parameter int MAX_SEQUENCE = 7,
   parameter int SEQ_W        = 3
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gbn_pkg::gbn_cmd_type          cmd,
   output gbn_pkg::gbn_stat_type              stat,
   input  wire logic [gbn_pkg::DATA_W-1:0]    req_payload,
   input  wire logic [gbn_pkg::ACK_W-1:0]     req_ack_number,
   output logic                               rsp_valid,
   output logic [gbn_pkg::STATUS_W-1:0]       rsp_status,
   output logic [SEQ_W-1:0]                   rsp_frame_seq,
   output logic [gbn_pkg::DATA_W-1:0]         rsp_frame_data,
   output logic                               rsp_last
);

   localparam int DEPTH = MAX_SEQUENCE + 1;
   localparam int CMP_W = (SEQ_W > gbn_pkg::ACK_W) ? SEQ_W : gbn_pkg::ACK_W;

   function automatic logic [SEQ_W-1:0] next_seq(input logic [SEQ_W-1:0] s);
      return (s == SEQ_W'(MAX_SEQUENCE)) ? '0 : s + 1'b1;
   endfunction

   logic [gbn_pkg::DATA_W-1:0] frame_mem [DEPTH];

   logic [SEQ_W-1:0] send_ptr_ff, send_ptr_in;
   logic [SEQ_W-1:0] oldest_ff, oldest_in;
   logic [SEQ_W-1:0] count_ff, count_in;
   logic [SEQ_W-1:0] rp_ff, rp_in;
   logic [SEQ_W-1:0] remain_ff, remain_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [gbn_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [SEQ_W-1:0]              rsp_seq_ff, rsp_seq_in;
   logic [gbn_pkg::DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                          rsp_last_ff, rsp_last_in;

   assign stat.window_full = (count_ff == SEQ_W'(MAX_SEQUENCE));
   assign stat.count_zero  = (count_ff == '0);
   assign stat.ack_match   = (count_ff != '0) &&
                             (CMP_W'(req_ack_number) == CMP_W'(oldest_ff));
   assign stat.replay_last = (remain_ff == SEQ_W'(1));

   always_comb begin
      send_ptr_in   = send_ptr_ff;
      oldest_in     = oldest_ff;
      count_in      = count_ff;
      rp_in         = rp_ff;
      remain_in     = remain_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = gbn_pkg::RSP_FRAME;
      rsp_seq_in    = '0;
      rsp_data_in   = '0;
      rsp_last_in   = 1'b1;
      priority if (cmd.op_send) begin
         rsp_valid_in = 1'b1;
         rsp_seq_in   = send_ptr_ff;
         rsp_data_in  = req_payload;
         count_in     = count_ff + 1'b1;
         send_ptr_in  = next_seq(send_ptr_ff);
      end else if (cmd.op_ack_ok) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = gbn_pkg::RSP_ACK_OK;
         rsp_seq_in    = oldest_ff;
         count_in      = count_ff - 1'b1;
         oldest_in     = next_seq(oldest_ff);
      end else if (cmd.op_ack_bad) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = gbn_pkg::RSP_ACK_BAD;
      end else if (cmd.op_full) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = gbn_pkg::RSP_FULL;
      end else if (cmd.op_empty) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = gbn_pkg::RSP_EMPTY;
      end else if (cmd.replay_load) begin
         rp_in     = oldest_ff;
         remain_in = count_ff;
      end else if (cmd.replay_step) begin
         // data comes straight from the store read below
         rsp_valid_in = 1'b1;
         rsp_seq_in   = rp_ff;
         rsp_last_in  = stat.replay_last;
         rp_in        = next_seq(rp_ff);
         remain_in    = remain_ff - 1'b1;
         send_ptr_in  = next_seq(rp_ff);
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         send_ptr_ff  <= '0;
         oldest_ff    <= '0;
         count_ff     <= '0;
         rp_ff        <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         send_ptr_ff  <= send_ptr_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         rp_ff        <= rp_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.op_send) begin
         frame_mem[send_ptr_ff] <= req_payload;
      end
      rsp_data_ff   <= cmd.replay_step ? frame_mem[rp_ff] : rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_frame_seq  = rsp_seq_ff;
   assign rsp_frame_data = rsp_data_ff;
   assign rsp_last       = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SEQ_W'(MAX_SEQUENCE))
      else $error("outstanding count above window");

   a_step_remain: assert property (@(posedge clock) disable iff (reset)
      cmd.replay_step |-> remain_ff != '0)
      else $error("replay step with nothing left");

   a_send_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.op_send |=> rsp_valid_ff && rsp_last_ff && rsp_status_ff == gbn_pkg::RSP_FRAME)
      else $error("send without frame beat");

endmodule

`default_nettype wire

>>> design/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl
// Command decode and replay sequencing for the go-back-n sender.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbn_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [gbn_pkg::CMD_W-1:0]    req_command,
   input  wire gbn_pkg::gbn_stat_type        stat,
   output gbn_pkg::gbn_cmd_type              cmd,
   output logic                              busy
);

   gbn_pkg::gbn_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b0;
      unique case (state_ff)
         gbn_pkg::ST_IDLE: begin
            if (start) begin
               unique case (req_command)
                  gbn_pkg::CMD_SEND: begin
                     cmd.op_send = !stat.window_full;
                     cmd.op_full = stat.window_full;
                  end
                  gbn_pkg::CMD_ACK: begin
                     cmd.op_ack_ok  = stat.ack_match;
                     cmd.op_ack_bad = !stat.ack_match;
                  end
                  gbn_pkg::CMD_TIMEOUT: begin
                     cmd.op_empty    = stat.count_zero;
                     cmd.replay_load = !stat.count_zero;
                     if (!stat.count_zero) begin
                        state_in = gbn_pkg::ST_REPLAY;
                     end
                  end
                  default: begin
                     cmd = '0;
                  end
               endcase
            end
         end
         gbn_pkg::ST_REPLAY: begin
            busy            = 1'b1;
            cmd.replay_step = 1'b1;
            if (stat.replay_last) begin
               state_in = gbn_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gbn_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbn_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_replay_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gbn_pkg::ST_REPLAY && !stat.replay_last) |=> state_ff == gbn_pkg::ST_REPLAY)
      else $error("replay ended early");

   a_replay_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gbn_pkg::ST_REPLAY && stat.replay_last) |=> state_ff == gbn_pkg::ST_IDLE)
      else $error("replay overran");

   a_empty_timeout: assert property (@(posedge clock) disable iff (reset)
      cmd.replay_load |-> !stat.count_zero)
      else $error("replay with empty window");

endmodule

`default_nettype wire

>>> design/go_back_n_sender_unit.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_unit
// Every result beat is registered and shows in the cycle after its command.
// Send, ack and refusals: one beat, busy stays low, a new command each cycle.
// Timeout with n frames outstanding: a load step, then n beats with busy high;
// with none, one empty beat. The frame store's single read port gives one
// frame per cycle. Results cannot be stalled. Reset clears pointers, count and
// state; the frame store is not cleared (only written entries are replayed).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_sender_unit #(
   parameter int  MAX_SEQUENCE = 7,
   localparam int SEQ_W        = $clog2(MAX_SEQUENCE + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // command channel
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [gbn_pkg::CMD_W-1:0]     req_command,
   input  wire logic [gbn_pkg::DATA_W-1:0]    req_payload,
   input  wire logic [gbn_pkg::ACK_W-1:0]     req_ack_number,
   // result channel, one beat per strobe
   output logic                               rsp_valid,
   output logic [gbn_pkg::STATUS_W-1:0]       rsp_status,
   output logic [SEQ_W-1:0]                   rsp_frame_seq,
   output logic [gbn_pkg::DATA_W-1:0]         rsp_frame_data,
   output logic                               rsp_last
);

   // controller decodes the command against window status; datapath owns
   // pointers (send, oldest unacked, replay), count and the frame store
   gbn_pkg::gbn_cmd_type  cmd;
   gbn_pkg::gbn_stat_type stat;

   gbn_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .stat        (stat),
      .cmd         (cmd),
      .busy        (busy)
   );

   gbn_datapath #(
      .MAX_SEQUENCE (MAX_SEQUENCE),
      .SEQ_W        (SEQ_W)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_payload    (req_payload),
      .req_ack_number (req_ack_number),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_frame_seq  (rsp_frame_seq),
      .rsp_frame_data (rsp_frame_data),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire
